// File: rtl/wtir_pkg.sv
// Shared types and constants for the wavetable interpolated read block.
`timescale 1ns / 1ps

package wtir_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int CFG_DATA_W  = 4;
  localparam int CFG_INDEX_W = 1;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_SELECT = 1'b0,
    CFG_INTERP_MODE  = 1'b1
  } cfg_index_t;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_type_t;

  typedef enum logic {
    MODE_LINEAR  = 1'b0,
    MODE_HERMITE = 1'b1
  } interp_mode_t;

  // control that travels alongside each lookup
  typedef struct packed {
    logic         valid;
    interp_mode_t mode;
  } lookup_ctrl_t;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

endpackage

// File: rtl/wtir_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module wtir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/wtir_bank_read.sv
// Four-bank sample store: write path, neighbor address generation, fetch stage.
`timescale 1ns / 1ps

module wtir_bank_read import wtir_pkg::*; #(
  parameter int TABLE_SIZE = 2048,
  parameter int NUM_FRAMES = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic                       wr_en,
  input  logic [3:0]                 load_frame,
  input  logic [10:0]                load_index,
  input  logic signed [SAMPLE_W-1:0] load_value,
  input  logic                       rd_en,
  input  logic [31:0]                phase,
  input  logic [3:0]                 frame_select,
  input  interp_mode_t               interp_mode,
  output lookup_ctrl_t               rd_ctrl,
  output logic [FRAC_BITS-1:0]       rd_u,
  output logic signed [SAMPLE_W-1:0] v [4]
);

  localparam int IB         = $clog2(TABLE_SIZE);
  localparam int FB         = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int QSH        = IB - 2;
  localparam int BANK_DEPTH = NUM_FRAMES * TABLE_SIZE / 4;
  localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // write side
  logic          write_ok;
  logic [IB-1:0] widx;
  logic [AW-1:0] waddr;

  assign write_ok = wr_en && (32'(load_frame) < 32'(NUM_FRAMES))
                    && (32'(load_index) < 32'(TABLE_SIZE));
  assign widx     = IB'(load_index);
  assign waddr    = (AW'(load_frame) << QSH) | AW'(widx >> 2);

  // lookup side
  logic [IB-1:0]        idx;
  logic [31:0]          ph_sh;
  logic [FRAC_BITS-1:0] u;
  logic [FB-1:0]        frame_eff;
  logic [1:0]           rot;
  logic [AW-1:0]        raddr [4];
  logic [SAMPLE_W-1:0]  rdata [4];
  logic [1:0]           rot_q;

  assign idx       = phase[31 -: IB];
  assign ph_sh     = phase << IB;
  assign u         = ph_sh[31 -: FRAC_BITS];
  assign frame_eff = (32'(frame_select) >= 32'(NUM_FRAMES)) ? FB'(NUM_FRAMES - 1)
                                                             : FB'(frame_select);
  // bank that holds the sample at idx-1
  assign rot       = idx[1:0] - 2'd1;

  always_comb begin
    logic [1:0]    ofs;
    logic [IB-1:0] k;
    for (int b = 0; b < 4; b++) begin
      ofs      = 2'(b) - rot;
      k        = idx - IB'(1) + IB'(ofs);
      raddr[b] = (AW'(frame_eff) << QSH) | AW'(k >> 2);
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    wtir_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (write_ok && (widx[1:0] == 2'(b))),
      .waddr (waddr),
      .wdata (load_value),
      .re    (advance),
      .raddr (raddr[b]),
      .rdata (rdata[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctrl.valid <= 1'b0;
    end else if (advance) begin
      rd_ctrl.valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rd_ctrl.mode <= interp_mode;
      rd_u         <= u;
      rot_q        <= rot;
    end
  end

  // undo the bank rotation: v[0..3] are the samples at idx-1 .. idx+2
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      v[j] = $signed(rdata[rot_q + 2'(j)]);
    end
  end

endmodule

// File: rtl/wtir_interp.sv
// Pipelined linear / cubic Hermite evaluation with output saturation.
`timescale 1ns / 1ps

module wtir_interp import wtir_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  lookup_ctrl_t               in_ctrl,
  input  logic [FRAC_BITS-1:0]       in_u,
  input  logic signed [SAMPLE_W-1:0] v [4],
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       clipped
);

  localparam int D_W   = SAMPLE_W + 1;
  localparam int A2_W  = 21;
  localparam int B2_W  = 22;
  localparam int ACC_W = 23;
  localparam int SUM_W = ACC_W + FRAC_BITS + 3;

  localparam logic signed [SUM_W-1:0] HALF_F  = SUM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] HALF_F1 = SUM_W'(1) <<< FRAC_BITS;

  // stage A: slopes and Horner coefficients
  logic signed [D_W-1:0]  s0_c, s1_c, d_c, diff_c;
  logic signed [A2_W-1:0] a2_c;
  logic signed [B2_W-1:0] b2_c;

  assign s0_c   = D_W'(v[2]) - D_W'(v[0]);
  assign s1_c   = D_W'(v[3]) - D_W'(v[1]);
  assign d_c    = D_W'(v[1]) - D_W'(v[2]);
  assign diff_c = D_W'(v[2]) - D_W'(v[1]);
  assign a2_c   = A2_W'(s0_c) + (A2_W'(d_c) <<< 2) + A2_W'(s1_c);
  assign b2_c   = (B2_W'(s0_c) <<< 1) + (B2_W'(d_c) <<< 2) + (B2_W'(d_c) <<< 1)
                  + B2_W'(s1_c);

  lookup_ctrl_t                a_ctrl;
  logic [FRAC_BITS-1:0]        a_u;
  logic signed [D_W-1:0]       a_s0, a_diff;
  logic signed [SAMPLE_W-1:0]  a_v1;
  logic signed [A2_W-1:0]      a_a2;
  logic signed [B2_W-1:0]      a_b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctrl.valid <= 1'b0;
    end else if (advance) begin
      a_ctrl.valid <= in_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_ctrl.mode <= in_ctrl.mode;
      a_u         <= in_u;
      a_s0        <= s0_c;
      a_diff      <= diff_c;
      a_v1        <= v[1];
      a_a2        <= a2_c;
      a_b2        <= b2_c;
    end
  end

  // stage B: p1 (Hermite) or the final linear value, one shared multiplier
  logic signed [FRAC_BITS:0]         a_us;
  logic signed [A2_W-1:0]            mul_op_b;
  logic signed [A2_W+FRAC_BITS:0]    prod_b;
  logic signed [SUM_W-1:0]           sum_b;

  assign a_us     = $signed({1'b0, a_u});
  assign mul_op_b = (a_ctrl.mode == MODE_HERMITE) ? a_a2 : A2_W'(a_diff);
  assign prod_b   = mul_op_b * a_us;
  assign sum_b    = (a_ctrl.mode == MODE_HERMITE)
                  ? SUM_W'(prod_b) - (SUM_W'(a_b2) <<< FRAC_BITS) + HALF_F
                  : SUM_W'(prod_b) + (SUM_W'(a_v1) <<< FRAC_BITS) + HALF_F;

  lookup_ctrl_t                b_ctrl;
  logic [FRAC_BITS-1:0]        b_u;
  logic signed [D_W-1:0]       b_s0;
  logic signed [SAMPLE_W-1:0]  b_v1;
  logic signed [ACC_W-1:0]     b_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctrl.valid <= 1'b0;
    end else if (advance) begin
      b_ctrl.valid <= a_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_ctrl.mode <= a_ctrl.mode;
      b_u         <= a_u;
      b_s0        <= a_s0;
      b_v1        <= a_v1;
      b_acc       <= ACC_W'(sum_b >>> FRAC_BITS);
    end
  end

  // stage C: p2
  logic signed [FRAC_BITS:0]        b_us;
  logic signed [ACC_W+FRAC_BITS:0]  prod_c;
  logic signed [SUM_W-1:0]          sum_c;

  assign b_us   = $signed({1'b0, b_u});
  assign prod_c = b_acc * b_us;
  assign sum_c  = SUM_W'(prod_c) + (SUM_W'(b_s0) <<< FRAC_BITS) + HALF_F;

  lookup_ctrl_t                c_ctrl;
  logic [FRAC_BITS-1:0]        c_u;
  logic signed [SAMPLE_W-1:0]  c_v1;
  logic signed [ACC_W-1:0]     c_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctrl.valid <= 1'b0;
    end else if (advance) begin
      c_ctrl.valid <= b_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c_ctrl.mode <= b_ctrl.mode;
      c_u         <= b_u;
      c_v1        <= b_v1;
      // linear results pass through unchanged
      c_acc       <= (b_ctrl.mode == MODE_HERMITE) ? ACC_W'(sum_c >>> FRAC_BITS) : b_acc;
    end
  end

  // stage D: final Hermite step, saturation, output register
  logic signed [FRAC_BITS:0]        c_us;
  logic signed [ACC_W+FRAC_BITS:0]  prod_d;
  logic signed [SUM_W-1:0]          sum_d;
  logic signed [ACC_W-1:0]          y_d;
  logic signed [SAMPLE_W-1:0]       sat_d;
  logic                             clip_d;

  assign c_us   = $signed({1'b0, c_u});
  assign prod_d = c_acc * c_us;
  assign sum_d  = SUM_W'(prod_d) + (SUM_W'(c_v1) <<< (FRAC_BITS + 1)) + HALF_F1;
  assign y_d    = (c_ctrl.mode == MODE_HERMITE) ? ACC_W'(sum_d >>> (FRAC_BITS + 1)) : c_acc;

  always_comb begin
    if (y_d > ACC_W'(SAMPLE_MAX)) begin
      sat_d  = SAMPLE_MAX;
      clip_d = 1'b1;
    end else if (y_d < ACC_W'(SAMPLE_MIN)) begin
      sat_d  = SAMPLE_MIN;
      clip_d = 1'b1;
    end else begin
      sat_d  = SAMPLE_W'(y_d);
      clip_d = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= c_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_out <= sat_d;
      clipped    <= clip_d;
    end
  end

endmodule

// File: rtl/wavetable_interpolated_read.sv
// Top level of the wavetable interpolated read block.
`timescale 1ns / 1ps

// Wavetable oscillator read-out. The table holds NUM_FRAMES frames of
// TABLE_SIZE signed Q1.15 samples, spread over four RAM banks by the low two
// index bits so that the four neighbors idx-1 .. idx+2 come out in one read.
// An input transaction is either a sample write (req_type 0) or a lookup
// (req_type 1). One transaction is accepted every clock while in_ready is
// high; a write lands in the RAM at its accept edge and is seen by any lookup
// accepted on a later edge. A lookup's result passes these registers in order:
// the RAM read registers at the accept edge, then a slope and coefficient
// stage, then three Horner stages with one multiplier each, the last of which
// feeds the saturation logic and the output register. Writes produce no
// result. The whole
// pipeline advances together; while a result waits on out_ready, in_ready is
// low, so nothing is dropped or duplicated. Linear and Hermite lookups share
// the same path and latency. The table has no reset: a lookup that touches a
// sample that was never written returns an unspecified value. Configuration
// (frame_select index 0, interp_mode index 1) is written through cfg_we,
// cfg_index and cfg_data, and is expected to change only with the pipeline
// empty; frame_select values past the last frame read the last frame.

module wavetable_interpolated_read import wtir_pkg::*; #(
  parameter int TABLE_SIZE = 2048,
  parameter int NUM_FRAMES = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       req_type,
  input  logic [3:0]                 load_frame,
  input  logic [10:0]                load_index,
  input  logic signed [SAMPLE_W-1:0] load_value,
  input  logic [31:0]                phase,
  // output channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       clipped,
  // configuration write port
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  logic         advance;
  logic         accept;
  logic         wr_en;
  logic         rd_en;
  logic [3:0]   frame_select;
  interp_mode_t interp_mode;

  lookup_ctrl_t               rd_ctrl;
  logic [FRAC_BITS-1:0]       rd_u;
  logic signed [SAMPLE_W-1:0] v [4];

  // global pipeline enable: move on unless the output register is held
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;
  assign wr_en    = accept && (req_type == REQ_WRITE);
  assign rd_en    = accept && (req_type == REQ_LOOKUP);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_select <= 4'd0;
      interp_mode  <= MODE_HERMITE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_SELECT: frame_select <= cfg_data;
        CFG_INTERP_MODE:  interp_mode  <= interp_mode_t'(cfg_data[0]);
        default: ;
      endcase
    end
  end

  // table banks and neighbor fetch (RAM read stage)
  wtir_bank_read #(
    .TABLE_SIZE (TABLE_SIZE),
    .NUM_FRAMES (NUM_FRAMES),
    .FRAC_BITS  (FRAC_BITS)
  ) u_bank_read (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .wr_en        (wr_en),
    .load_frame   (load_frame),
    .load_index   (load_index),
    .load_value   (load_value),
    .rd_en        (rd_en),
    .phase        (phase),
    .frame_select (frame_select),
    .interp_mode  (interp_mode),
    .rd_ctrl      (rd_ctrl),
    .rd_u         (rd_u),
    .v            (v)
  );

  // coefficient, Horner and saturation stages
  wtir_interp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_interp (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_ctrl    (rd_ctrl),
    .in_u       (rd_u),
    .v          (v),
    .out_valid  (out_valid),
    .sample_out (sample_out),
    .clipped    (clipped)
  );

endmodule

// File: rtl/wtir_checker.sv
// Port-level checks for the wavetable interpolated read block, bound to the top.
`timescale 1ns / 1ps

module wtir_checker import wtir_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] sample_out,
  input logic                       clipped
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(clipped))
    else $error("output transaction changed while stalled");

  // a stalled output stops the input side
  a_stall_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // a clipped result sits at one of the rails
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> sample_out == SAMPLE_MAX || sample_out == SAMPLE_MIN)
    else $error("clipped flag with unsaturated sample");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind wavetable_interpolated_read wtir_checker u_wtir_checker (.*);

// File: dv/tb_wavetable_interpolated_read.sv
// Self-checking testbench for the wavetable interpolated read block.
`timescale 1ns / 1ps

module tb_wavetable_interpolated_read;
  import wtir_pkg::*;

  // Block configuration (defaults of the top level)
  localparam int TABLE_SIZE = 2048;
  localparam int NUM_FRAMES = 16;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam longint ONE    = 64'sd1 << FRAC_BITS;

  // Pipeline is 5 deep; allow some slack after the last result
  localparam int SETTLE_CYCLES   = 8;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int NUM_PHASES      = 5;
  localparam int QUIET_PHASE     = 2;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int MAX_REPORTS     = 200;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clip;
  } interp_result_t;

  // Table shadow, active settings and the queue of lookup results still owed
  class interp_scoreboard;
    logic signed [SAMPLE_W-1:0] samples [NUM_FRAMES*TABLE_SIZE];
    bit                         written [NUM_FRAMES*TABLE_SIZE];
    int unsigned                eff_frame;
    interp_mode_t               mode;
    interp_result_t             owed_q[$];
    int                         errors;

    function new();
      eff_frame = 0;
      mode      = MODE_HERMITE;
      errors    = 0;
    endfunction

    function void set_config(input logic [3:0] frame_sel, input interp_mode_t m);
      eff_frame = (frame_sel >= NUM_FRAMES) ? NUM_FRAMES - 1 : frame_sel;
      mode      = m;
    endfunction

    // round half up: floor((x + 2^(s-1)) / 2^s)
    static function longint rnd(input longint x, input int s);
      return (x + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function longint tap(input int unsigned ix);
      return longint'(samples[eff_frame*TABLE_SIZE + (ix % TABLE_SIZE)]);
    endfunction

    // true when all four neighbors idx-1 .. idx+2 of the active frame hold data
    function bit readable(input int unsigned ix);
      bit ok;
      ok = 1'b1;
      for (int k = 0; k < 4; k++)
        ok &= written[eff_frame*TABLE_SIZE + ((ix + TABLE_SIZE + k - 1) % TABLE_SIZE)];
      return ok;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void note_input(input req_type_t rt, input logic [3:0] fr,
                             input logic [10:0] ix, input logic signed [15:0] val,
                             input logic [31:0] ph);
      int unsigned    ti;
      longint         u, v0, v1, v2, v3, s0, s1, d, a2, b2, p1, p2, y;
      interp_result_t r;
      if (rt == REQ_WRITE) begin
        if (fr < NUM_FRAMES && ix < TABLE_SIZE) begin
          samples[fr*TABLE_SIZE + ix] = val;
          written[fr*TABLE_SIZE + ix] = 1'b1;
        end
      end else begin
        ti = ph[31 -: IDX_W];
        u  = ph[31-IDX_W -: FRAC_BITS];
        v1 = tap(ti);
        v2 = tap(ti + 1);
        if (mode == MODE_LINEAR) begin
          y = rnd(v1 * ONE + u * (v2 - v1), FRAC_BITS);
        end else begin
          // Catmull-Rom in half-LSB units, Horner form
          v0 = tap(ti + TABLE_SIZE - 1);
          v3 = tap(ti + 2);
          s0 = v2 - v0;
          s1 = v3 - v1;
          d  = v1 - v2;
          a2 = s0 + 4 * d + s1;
          b2 = 2 * s0 + 6 * d + s1;
          p1 = rnd(a2 * u - b2 * ONE, FRAC_BITS);
          p2 = rnd(p1 * u + s0 * ONE, FRAC_BITS);
          y  = rnd(p2 * u + 2 * v1 * ONE, FRAC_BITS + 1);
        end
        r.clip = 1'b0;
        if (y > 32767) begin
          y      = 32767;
          r.clip = 1'b1;
        end else if (y < -32768) begin
          y      = -32768;
          r.clip = 1'b1;
        end
        r.sample = y[15:0];
        owed_q = {owed_q, r};
      end
    endfunction

    function void check_result(input logic signed [15:0] sample, input logic clip);
      interp_result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with nothing owed: sample_out=%0d clipped=%0b",
                   $time, sample, clip);
      end else begin
        want = owed_q.pop_front();
        if (sample !== want.sample) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                     $time, want.sample, sample);
        end
        if (clip !== want.clip) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: clipped mismatch: expected %0b, actual %0b",
                     $time, want.clip, clip);
        end
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  req_type_t                  req_type;
  logic [3:0]                 load_frame;
  logic [10:0]                load_index;
  logic signed [SAMPLE_W-1:0] load_value;
  logic [31:0]                phase;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       clipped;
  logic                       cfg_we;
  logic [CFG_INDEX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  interp_scoreboard board;
  bit               idle_on = 1'b1;   // cleared for the quiet phase: no bubbles, no stalls
  int               cycle_count = 0;
  logic [10:0]      live_idx[$];      // indexes written in the active frame since last reconfig

  wavetable_interpolated_read u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .load_frame (load_frame),
    .load_index (load_index),
    .load_value (load_value),
    .phase      (phase),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .clipped    (clipped),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a healthy run ends far below this
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver backpressure: ~30% stall cycles unless in the quiet phase
  always @(posedge clk) begin
    out_ready <= !(idle_on && $urandom_range(99) < 30);
  end

  // Output monitor: every accepted result transaction goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result(sample_out, clipped);
  end

  // Present one input transaction, after optional random bubbles, and hold it
  // until accepted. Returns in the time step of the accepting edge with
  // in_valid still high; the caller's next drive replaces it.
  task automatic send_item(input req_type_t rt, input logic [3:0] fr, input logic [10:0] ix,
                           input logic signed [15:0] val, input logic [31:0] ph);
    while (idle_on && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= rt;
    load_frame <= fr;
    load_index <= ix;
    load_value <= val;
    phase      <= ph;
    do @(posedge clk); while (!in_ready);
    board.note_input(rt, fr, ix, val, ph);
  endtask

  // Drain the pipeline, then write both registers back to back.
  // Upper data bits of the mode write are junk on purpose: only bit 0 counts.
  task automatic reconfigure(input logic [3:0] fr, input interp_mode_t m);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_SELECT;
    cfg_data  <= fr;
    @(posedge clk);
    cfg_index <= CFG_INTERP_MODE;
    cfg_data  <= CFG_DATA_W'({$urandom_range(7), m});
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_config(fr, m);
    live_idx.delete();
  endtask

  initial begin
    int                sent;
    int                run_len;
    int                nv;
    bit                found;
    logic [10:0]       base;
    logic [10:0]       ix;
    logic [3:0]        fr;
    logic signed [15:0] val;
    logic [20:0]       frac;
    interp_mode_t      m;

    board = new();
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    req_type   <= REQ_WRITE;
    load_frame <= '0;
    load_index <= '0;
    load_value <= '0;
    phase      <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_FRAME_SELECT;
    cfg_data   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // ---- Directed part (reset config: frame 0, Hermite) ----
    // Alternating full-scale samples around the wrap point force Hermite overshoot.
    send_item(REQ_WRITE, 4'd0, 11'd2046, SAMPLE_MIN, 32'($urandom));
    send_item(REQ_WRITE, 4'd0, 11'd2047, SAMPLE_MAX, 32'($urandom));
    send_item(REQ_WRITE, 4'd0, 11'd0,    SAMPLE_MIN, 32'($urandom));
    send_item(REQ_WRITE, 4'd0, 11'd1,    SAMPLE_MAX, 32'($urandom));
    send_item(REQ_WRITE, 4'd0, 11'd2,    SAMPLE_MIN, 32'($urandom));
    send_item(REQ_WRITE, 4'd0, 11'd3,    SAMPLE_MAX, 32'($urandom));
    // a small run in the last frame
    send_item(REQ_WRITE, 4'd15, 11'd1024, 16'sd100,  32'($urandom));
    send_item(REQ_WRITE, 4'd15, 11'd1025, -16'sd200, 32'($urandom));
    send_item(REQ_WRITE, 4'd15, 11'd1026, 16'sd300,  32'($urandom));
    send_item(REQ_WRITE, 4'd15, 11'd1027, 16'sd0,    32'($urandom));
    // Hermite: offset zero, half, all ones; both wrap directions
    send_item(REQ_LOOKUP, 4'd0, 11'd0, 16'sd0, 32'h0000_0000);
    send_item(REQ_LOOKUP, 4'd0, 11'd0, 16'sd0, 32'h0010_0000);
    send_item(REQ_LOOKUP, 4'd0, 11'd0, 16'sd0, 32'h001F_FFFF);
    send_item(REQ_LOOKUP, 4'd0, 11'd0, 16'sd0, 32'hFFEC_0000);
    send_item(REQ_LOOKUP, 4'd0, 11'd0, 16'sd0, 32'h002A_AAAA);
    send_item(REQ_LOOKUP, 4'd0, 11'd0, 16'sd0, 32'hFFFF_FFFF);
    // Linear on the same data, including the last-to-first wrap
    reconfigure(4'd0, MODE_LINEAR);
    send_item(REQ_LOOKUP, 4'd0, 11'd0, 16'sd0, 32'h0010_0000);
    send_item(REQ_LOOKUP, 4'd0, 11'd0, 16'sd0, 32'h001F_FFFF);
    send_item(REQ_LOOKUP, 4'd0, 11'd0, 16'sd0, 32'h0045_5555);
    send_item(REQ_LOOKUP, 4'd0, 11'd0, 16'sd0, 32'hFFF0_0000);
    // Last frame, Hermite
    reconfigure(4'd15, MODE_HERMITE);
    send_item(REQ_LOOKUP, 4'd0, 11'd0, 16'sd0, 32'h8035_5555);
    send_item(REQ_LOOKUP, 4'd0, 11'd0, 16'sd0, 32'h8020_0000);

    // ---- Random part: one block of transactions per setting ----
    for (int pi = 0; pi < NUM_PHASES; pi++) begin
      case (pi)
        0:       begin fr = 4'd0;                 m = MODE_LINEAR;  end
        1:       begin fr = 4'd15;                m = MODE_HERMITE; end
        2:       begin fr = 4'd15;                m = MODE_LINEAR;  end
        3:       begin fr = 4'($urandom_range(15)); m = MODE_HERMITE; end
        default: begin
          fr = 4'($urandom_range(15));
          m  = interp_mode_t'($urandom_range(1));
        end
      endcase
      idle_on = (pi != QUIET_PHASE);
      reconfigure(fr, m);

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 25) begin
          // Run of consecutive writes: mostly into the active frame so that
          // lookups find four written neighbors; short runs now and then.
          run_len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 8);
          fr      = ($urandom_range(4) == 0) ? 4'($urandom_range(NUM_FRAMES - 1))
                                             : 4'(board.eff_frame);
          base    = 11'($urandom);
          val     = 16'($urandom);
          for (int k = 0; k < run_len; k++) begin
            case ($urandom_range(2))
              0: val = 16'($urandom);
              1: begin
                // smooth waveform: small step from the previous sample
                nv = int'(val) + $urandom_range(2000) - 1000;
                if (nv > 32767) nv = 32767;
                if (nv < -32768) nv = -32768;
                val = 16'(nv);
              end
              default: val = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
            endcase
            ix = base + 11'(k);
            send_item(REQ_WRITE, fr, ix, val, 32'($urandom));
            if (fr == board.eff_frame) live_idx = {live_idx, ix};
            sent++;
          end
        end else begin
          // Lookup at a point whose neighborhood is fully written
          found = 1'b0;
          for (int t = 0; t < 6 && !found && live_idx.size() > 0; t++) begin
            ix    = live_idx[$urandom_range(live_idx.size() - 1)];
            found = board.readable(ix);
          end
          if (found) begin
            case ($urandom_range(7))
              0:       frac = '0;
              1:       frac = '1;
              default: frac = 21'($urandom);
            endcase
            send_item(REQ_LOOKUP, 4'($urandom), 11'($urandom), 16'($urandom), {ix, frac});
          end else begin
            // noise: a lone write anywhere
            send_item(REQ_WRITE, 4'($urandom), 11'($urandom), 16'($urandom),
                      32'($urandom));
          end
          sent++;
        end
      end
    end

    // ---- Wind down ----
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
